// ----- src/affine_rect_bounds_macros.svh -----
// ----------------------------------------------------------------------------
// affine_rect_bounds assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef AFFINE_RECT_BOUNDS_MACROS_SVH
`define AFFINE_RECT_BOUNDS_MACROS_SVH

// same-cycle implication
`define ARB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ARB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- src/arb_pkg.sv -----
// ----------------------------------------------------------------------------
// arb_pkg
// Types and fixed constants shared by the affine bounding box pipeline.
// ----------------------------------------------------------------------------
package arb_pkg;

   // Q16.16 fraction bits dropped after each product
   localparam int FRAC_BITS = 16;

   // 1.0 in Q16.16, wide enough for coordinate widths up to 48 bits
   localparam logic [47:0] ONE_Q16 = 48'h0000_0001_0000;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_M00 = 3'd0,
      CSR_M01 = 3'd1,
      CSR_TX  = 3'd2,
      CSR_M10 = 3'd3,
      CSR_M11 = 3'd4,
      CSR_TY  = 3'd5
   } csr_index_type;

   // per-stage load enables
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
      logic en4;
   } pipe_ctrl_type;

endpackage

// ----- src/affine_rect_bounds.sv -----
// ----------------------------------------------------------------------------
// affine_rect_bounds - affine map of a rectangle and its bounding box
// Registered stages in order: partial products, product combine, sum/saturate, min/max.
// Throughput one rectangle per cycle while rsp_stall is low; a stalled stage holds, bubbles collapse.
// Synchronous reset empties the pipeline and restores the identity transform.
// ----------------------------------------------------------------------------
module affine_rect_bounds
   import arb_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_max_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_min_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_min_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_max_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_max_y,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata
);

   `include "affine_rect_bounds_macros.svh"

   localparam int PW = 2 * COORD_WIDTH - FRAC_BITS;

   // transform registers
   logic signed [COORD_WIDTH-1:0] m00_ff, m01_ff, tx_ff, m10_ff, m11_ff, ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m00_ff <= ONE_Q16[COORD_WIDTH-1:0];
         m01_ff <= '0;
         tx_ff  <= '0;
         m10_ff <= '0;
         m11_ff <= ONE_Q16[COORD_WIDTH-1:0];
         ty_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_M00: m00_ff <= csr_wdata;
            CSR_M01: m01_ff <= csr_wdata;
            CSR_TX:  tx_ff  <= csr_wdata;
            CSR_M10: m10_ff <= csr_wdata;
            CSR_M11: m11_ff <= csr_wdata;
            CSR_TY:  ty_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valids and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;
   pipe_ctrl_type ctrl;

   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign ctrl.en1 = rdy1 && req_valid;
   assign ctrl.en2 = rdy2 && v1_ff;
   assign ctrl.en3 = rdy3 && v2_ff;
   assign ctrl.en4 = rdy4 && v3_ff;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff     : v2_ff;
   assign v3_in = rdy3 ? v2_ff     : v3_ff;
   assign v4_in = rdy4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_stall = !rdy1;
   assign rsp_valid = v4_ff;

   // products: x row then y row, each coefficient against both edges
   logic signed [COORD_WIDTH-1:0] mul_coord [8];
   logic signed [COORD_WIDTH-1:0] mul_coef  [8];
   logic signed [PW-1:0]          prod      [8];

   assign mul_coord[0] = req_min_x;  assign mul_coef[0] = m00_ff;
   assign mul_coord[1] = req_max_x;  assign mul_coef[1] = m00_ff;
   assign mul_coord[2] = req_min_y;  assign mul_coef[2] = m01_ff;
   assign mul_coord[3] = req_max_y;  assign mul_coef[3] = m01_ff;
   assign mul_coord[4] = req_min_x;  assign mul_coef[4] = m10_ff;
   assign mul_coord[5] = req_max_x;  assign mul_coef[5] = m10_ff;
   assign mul_coord[6] = req_min_y;  assign mul_coef[6] = m11_ff;
   assign mul_coord[7] = req_max_y;  assign mul_coef[7] = m11_ff;

   for (genvar g = 0; g < 8; g++) begin : g_mul
      arb_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
         .clock (clock),
         .ctrl  (ctrl),
         .coord (mul_coord[g]),
         .coef  (mul_coef[g]),
         .prod  (prod[g])
      );
   end

   // corners: (min_x,min_y), (min_x,max_y), (max_x,max_y), (max_x,min_y)
   logic signed [COORD_WIDTH-1:0] px [4];
   logic signed [COORD_WIDTH-1:0] py [4];
   logic signed [PW-1:0] px_a [4], px_b [4], py_a [4], py_b [4];

   assign px_a[0] = prod[0];  assign px_b[0] = prod[2];
   assign px_a[1] = prod[0];  assign px_b[1] = prod[3];
   assign px_a[2] = prod[1];  assign px_b[2] = prod[3];
   assign px_a[3] = prod[1];  assign px_b[3] = prod[2];
   assign py_a[0] = prod[4];  assign py_b[0] = prod[6];
   assign py_a[1] = prod[4];  assign py_b[1] = prod[7];
   assign py_a[2] = prod[5];  assign py_b[2] = prod[7];
   assign py_a[3] = prod[5];  assign py_b[3] = prod[6];

   for (genvar g = 0; g < 4; g++) begin : g_corner
      arb_corner #(.COORD_WIDTH(COORD_WIDTH)) u_cx (
         .clock  (clock),
         .ctrl   (ctrl),
         .prod_a (px_a[g]),
         .prod_b (px_b[g]),
         .trans  (tx_ff),
         .coord  (px[g])
      );
      arb_corner #(.COORD_WIDTH(COORD_WIDTH)) u_cy (
         .clock  (clock),
         .ctrl   (ctrl),
         .prod_a (py_a[g]),
         .prod_b (py_b[g]),
         .trans  (ty_ff),
         .coord  (py[g])
      );
   end

   arb_bound #(.COORD_WIDTH(COORD_WIDTH)) u_bound_x (
      .clock (clock),
      .ctrl  (ctrl),
      .c0    (px[0]),
      .c1    (px[1]),
      .c2    (px[2]),
      .c3    (px[3]),
      .lo    (rsp_out_min_x),
      .hi    (rsp_out_max_x)
   );

   arb_bound #(.COORD_WIDTH(COORD_WIDTH)) u_bound_y (
      .clock (clock),
      .ctrl  (ctrl),
      .c0    (py[0]),
      .c1    (py[1]),
      .c2    (py[2]),
      .c3    (py[3]),
      .lo    (rsp_out_min_y),
      .hi    (rsp_out_max_y)
   );

   // a full, blocked pipeline must push back on the request side
   `ARB_ASSERT_SAME(a_full_stalls, clock, reset, v1_ff && v2_ff && v3_ff && rsp_valid && rsp_stall, req_stall)
   // an accepted rectangle lands in the first stage
   `ARB_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && !req_stall, v1_ff)
   // a finished sum advances to the output when the output is free
   `ARB_ASSERT_NEXT(a_stage3_moves, clock, reset, v3_ff && !(rsp_valid && rsp_stall), rsp_valid)
   // a write to the x coefficient lands as written
   `ARB_ASSERT_NEXT(a_csr_m00, clock, reset, csr_we && (csr_index == CSR_M00), m00_ff == $past(csr_wdata))

endmodule

// ----- src/arb_mul.sv -----
// ----------------------------------------------------------------------------
// arb_mul
// Two-stage signed Q16.16 multiplier: split partial products, then combine
// and drop the fraction bits (floor).
// ----------------------------------------------------------------------------
module arb_mul
   import arb_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                     clock,
   input  pipe_ctrl_type                            ctrl,
   input  logic signed [COORD_WIDTH-1:0]            coord,
   input  logic signed [COORD_WIDTH-1:0]            coef,
   output logic signed [2*COORD_WIDTH-FRAC_BITS-1:0] prod
);

   localparam int LO_W   = COORD_WIDTH / 2;
   localparam int HI_W   = COORD_WIDTH - LO_W;
   localparam int PLO_W  = COORD_WIDTH + LO_W + 1;
   localparam int PHI_W  = COORD_WIDTH + HI_W;
   localparam int FULL_W = 2 * COORD_WIDTH;

   logic signed [PLO_W-1:0]  plo_in, plo_ff;
   logic signed [PHI_W-1:0]  phi_in, phi_ff;
   logic signed [FULL_W-1:0] full_sum;
   logic signed [FULL_W-FRAC_BITS-1:0] prod_in, prod_ff;

   // low half of the coefficient is unsigned, high half carries the sign
   assign plo_in = PLO_W'(coord) * PLO_W'($signed({1'b0, coef[LO_W-1:0]}));
   assign phi_in = PHI_W'(coord) * PHI_W'($signed(coef[COORD_WIDTH-1:LO_W]));

   always_ff @(posedge clock) begin
      if (ctrl.en1) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
   end

   assign full_sum = ({{(FULL_W-PHI_W){phi_ff[PHI_W-1]}}, phi_ff} <<< LO_W)
                   + {{(FULL_W-PLO_W){plo_ff[PLO_W-1]}}, plo_ff};

   // top bits of a two's complement word give the arithmetic shift
   assign prod_in = full_sum[FULL_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (ctrl.en2) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- src/arb_corner.sv -----
// ----------------------------------------------------------------------------
// arb_corner
// One mapped coordinate: two products plus translation, saturated.
// ----------------------------------------------------------------------------
module arb_corner
   import arb_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                     clock,
   input  pipe_ctrl_type                            ctrl,
   input  logic signed [2*COORD_WIDTH-FRAC_BITS-1:0] prod_a,
   input  logic signed [2*COORD_WIDTH-FRAC_BITS-1:0] prod_b,
   input  logic signed [COORD_WIDTH-1:0]            trans,
   output logic signed [COORD_WIDTH-1:0]            coord
);

   localparam int PW = 2 * COORD_WIDTH - FRAC_BITS;
   localparam int SW = PW + 2;

   logic signed [SW-1:0]          sum;
   logic                          fits;
   logic signed [COORD_WIDTH-1:0] coord_in, coord_ff;

   assign sum = {{2{prod_a[PW-1]}}, prod_a}
              + {{2{prod_b[PW-1]}}, prod_b}
              + {{(SW-COORD_WIDTH){trans[COORD_WIDTH-1]}}, trans};

   // in range when every bit above the target sign matches it
   assign fits = (sum[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){sum[SW-1]}});

   always_comb begin
      priority if (fits) begin
         coord_in = sum[COORD_WIDTH-1:0];
      end else if (sum[SW-1]) begin
         coord_in = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         coord_in = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en3) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

// ----- src/arb_bound.sv -----
// ----------------------------------------------------------------------------
// arb_bound
// Least and greatest of four mapped coordinates, registered.
// ----------------------------------------------------------------------------
module arb_bound
   import arb_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  pipe_ctrl_type                 ctrl,
   input  logic signed [COORD_WIDTH-1:0] c0,
   input  logic signed [COORD_WIDTH-1:0] c1,
   input  logic signed [COORD_WIDTH-1:0] c2,
   input  logic signed [COORD_WIDTH-1:0] c3,
   output logic signed [COORD_WIDTH-1:0] lo,
   output logic signed [COORD_WIDTH-1:0] hi
);

   logic signed [COORD_WIDTH-1:0] lo01, lo23, hi01, hi23;
   logic signed [COORD_WIDTH-1:0] lo_in, hi_in, lo_ff, hi_ff;

   assign lo01  = (c1 < c0) ? c1 : c0;
   assign lo23  = (c3 < c2) ? c3 : c2;
   assign hi01  = (c1 > c0) ? c1 : c0;
   assign hi23  = (c3 > c2) ? c3 : c2;
   assign lo_in = (lo23 < lo01) ? lo23 : lo01;
   assign hi_in = (hi23 > hi01) ? hi23 : hi01;

   always_ff @(posedge clock) begin
      if (ctrl.en4) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule
